/* hdl/rgbhsv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rgbhsv_pkg;

  // one input pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // one converted pixel
  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness_value;
  } hsv_t;

  // data carried through the divider stages
  typedef struct packed {
    logic [7:0]  mx;       // largest channel, saturation divisor
    logic [7:0]  chroma;   // max - min, hue divisor
    logic [15:0] rem_s;    // saturation partial remainder
    logic [13:0] rem_h;    // hue partial remainder
    logic [7:0]  q_s;      // saturation quotient bits
    logic [7:0]  q_h;      // hue quotient bits
    logic [7:0]  hue_ofs;  // sector offset
    logic        neg;      // hue difference below zero
    logic        grey;     // chroma zero, hue and saturation forced to zero
  } pipe_t;

  localparam logic [5:0] HUE_SPAN      = 6'd43;
  localparam logic [7:0] HUE_OFS_RED   = 8'd0;
  localparam logic [7:0] HUE_OFS_GREEN = 8'd85;
  localparam logic [7:0] HUE_OFS_BLUE  = 8'd171;

  localparam int DIV_STAGES = 4;  // two quotient bits per stage

  // one restoring step on both dividers at quotient bit sh
  function automatic pipe_t div_step(pipe_t d, logic [2:0] sh);
    pipe_t      o;
    logic [15:0] ds;
    logic [15:0] dh;
    logic [15:0] rh;
    o  = d;
    ds = {8'h00, d.mx} << sh;
    dh = {8'h00, d.chroma} << sh;
    rh = {2'b00, d.rem_h};
    if (d.rem_s >= ds) begin
      o.rem_s  = d.rem_s - ds;
      o.q_s[sh] = 1'b1;
    end
    if (rh >= dh) begin
      o.rem_h  = 14'(rh - dh);
      o.q_h[sh] = 1'b1;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

/* hdl/rgb_to_hsv_convert.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                          transfer when
// pixel in  in_valid, in_ready, in_data    in_valid && in_ready
// hsv out   out_valid, out_ready, out_data out_valid && out_ready
//
// one pixel per cycle sustained while out_ready is high
// pipeline depth set by the two restoring dividers, two quotient bits per stage
// rst_n is synchronous and active low; it empties every stage
// each stage holds its item until the next one frees, so empty stages
// still take new pixels while a finished result waits at the output

module rgb_to_hsv_convert (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire rgbhsv_pkg::rgb_t in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output rgbhsv_pkg::hsv_t     out_data
);

  import rgbhsv_pkg::*;

  // front stage, divider stages, output stage
  localparam int NSTG = DIV_STAGES + 2;

  logic [NSTG-1:0] v_r;
  logic [NSTG:0]   adv;

  pipe_t pipe_r   [DIV_STAGES+1];
  pipe_t pipe_nxt [DIV_STAGES+1];
  hsv_t  out_r;
  hsv_t  out_nxt;

  // front stage signals
  logic [7:0] mx, mn, chroma, mag;
  logic [8:0] diff;

  // a stage may load when it is empty or its item moves on
  always_comb begin
    adv[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NSTG-1];
  assign out_data  = out_r;

  // front: max, min, sector, and both numerators
  always_comb begin
    mx = (in_data.red > in_data.green) ? in_data.red : in_data.green;
    mx = (mx > in_data.blue) ? mx : in_data.blue;
    mn = (in_data.red < in_data.green) ? in_data.red : in_data.green;
    mn = (mn < in_data.blue) ? mn : in_data.blue;
    chroma = mx - mn;

    pipe_nxt[0] = '0;
    // red wins ties, then green
    if (mx == in_data.red) begin
      diff = {1'b0, in_data.green} - {1'b0, in_data.blue};
      pipe_nxt[0].hue_ofs = HUE_OFS_RED;
    end else if (mx == in_data.green) begin
      diff = {1'b0, in_data.blue} - {1'b0, in_data.red};
      pipe_nxt[0].hue_ofs = HUE_OFS_GREEN;
    end else begin
      diff = {1'b0, in_data.red} - {1'b0, in_data.green};
      pipe_nxt[0].hue_ofs = HUE_OFS_BLUE;
    end
    mag = diff[8] ? 8'(-diff) : diff[7:0];

    pipe_nxt[0].mx     = mx;
    pipe_nxt[0].chroma = chroma;
    pipe_nxt[0].neg    = diff[8];
    pipe_nxt[0].grey   = (chroma == 8'h00);
    // 255 * chroma as a shift and subtract
    pipe_nxt[0].rem_s  = {chroma, 8'h00} - {8'h00, chroma};
    pipe_nxt[0].rem_h  = {6'b0, mag} * {8'b0, HUE_SPAN};

    // divider stages, quotient bits from the top down
    for (int k = 1; k <= DIV_STAGES; k++) begin
      pipe_nxt[k] = div_step(div_step(pipe_r[k-1], 3'(2 * DIV_STAGES + 1 - 2 * k)),
                             3'(2 * DIV_STAGES - 2 * k));
    end
  end

  // output: signed quotient folded into the sector offset, wraps mod 256; grey pixels get zero hue and saturation
  always_comb begin
    pipe_t d;
    d = pipe_r[DIV_STAGES];
    out_nxt.brightness_value = d.mx;
    if (d.grey) begin
      out_nxt.hue        = 8'h00;
      out_nxt.saturation = 8'h00;
    end else begin
      out_nxt.hue        = d.neg ? (d.hue_ofs - d.q_h) : (d.hue_ofs + d.q_h);
      out_nxt.saturation = d.q_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= DIV_STAGES; k++) begin
      if (adv[k]) pipe_r[k] <= pipe_nxt[k];
    end
    if (adv[NSTG-1]) out_r <= out_nxt;
  end

  // grey and black pixels carry no hue
  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturation == 8'h00 |-> out_data.hue == 8'h00)
    else $error("hue set on a grey pixel");

  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.brightness_value == 8'h00 |-> out_data.saturation == 8'h00)
    else $error("saturation set on a black pixel");

  // input only held off when every stage is occupied
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r) && !out_ready)
    else $error("input stalled with a free stage");

  // an output transfer always frees room for a new pixel
  a_drain_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> in_ready)
    else $error("input stalled while output drains");

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rgbhsv_pkg::*;

  localparam int RANDOM_PIXELS = 600;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int TAIL_CYCLES   = 20;
  localparam int TABLE_ROWS    = 24;

  // one row of directed stimulus: pixel, whether the result is typed in, and that result
  typedef struct packed {
    rgb_t pix;
    logic known;
    hsv_t want;
  } pixel_case_t;

  //                             red     green   blue    known  hue     sat     value
  localparam pixel_case_t PIXEL_TABLE [0:TABLE_ROWS-1] = '{
    {8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0  },  // black
    {8'd255, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255},  // white
    {8'd128, 8'd128, 8'd128, 1'b1, 8'd0,   8'd0,   8'd128},  // grey
    {8'd1,   8'd1,   8'd1,   1'b1, 8'd0,   8'd0,   8'd1  },  // dark grey
    {8'd255, 8'd0,   8'd0,   1'b1, 8'd0,   8'd255, 8'd255},  // pure red
    {8'd0,   8'd255, 8'd0,   1'b1, 8'd85,  8'd255, 8'd255},  // pure green
    {8'd0,   8'd0,   8'd255, 1'b1, 8'd171, 8'd255, 8'd255},  // pure blue
    {8'd255, 8'd255, 8'd0,   1'b1, 8'd43,  8'd255, 8'd255},  // red beats green on a tie
    {8'd0,   8'd255, 8'd255, 1'b1, 8'd128, 8'd255, 8'd255},  // green beats blue on a tie
    {8'd255, 8'd0,   8'd255, 1'b1, 8'd213, 8'd255, 8'd255},  // red beats blue, hue wraps
    {8'd1,   8'd0,   8'd0,   1'b1, 8'd0,   8'd255, 8'd1  },
    {8'd0,   8'd1,   8'd0,   1'b1, 8'd85,  8'd255, 8'd1  },
    {8'd0,   8'd0,   8'd1,   1'b1, 8'd171, 8'd255, 8'd1  },
    {8'd255, 8'd254, 8'd254, 1'b1, 8'd0,   8'd1,   8'd255},  // smallest saturation
    {8'd2,   8'd1,   8'd1,   1'b1, 8'd0,   8'd127, 8'd2  },  // saturation truncates
    {8'd255, 8'd0,   8'd128, 1'b0, 8'd0,   8'd0,   8'd0  },  // red max, hue below zero
    {8'd255, 8'd0,   8'd254, 1'b0, 8'd0,   8'd0,   8'd0  },
    {8'd255, 8'd0,   8'd1,   1'b0, 8'd0,   8'd0,   8'd0  },  // quotient truncates to zero
    {8'd10,  8'd20,  8'd200, 1'b0, 8'd0,   8'd0,   8'd0  },  // blue max, negative diff
    {8'd200, 8'd250, 8'd100, 1'b0, 8'd0,   8'd0,   8'd0  },  // green max, negative diff
    {8'd170, 8'd85,  8'd0,   1'b0, 8'd0,   8'd0,   8'd0  },
    {8'd85,  8'd170, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0  },
    {8'd254, 8'd253, 8'd1,   1'b0, 8'd0,   8'd0,   8'd0  },
    {8'd255, 8'd254, 8'd0,   1'b0, 8'd0,   8'd0,   8'd0  }
  };

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  rgb_t in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  hsv_t out_data;

  hsv_t hsv_expected [$];
  int   mismatches = 0;
  int   cycles     = 0;
  bit   no_gaps    = 1'b0;

  rgb_to_hsv_convert dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // hsv of one pixel; hue quotient is signed and truncates toward zero
  function automatic hsv_t hsv_of(rgb_t p);
    int   r, g, b, mx, mn, chroma, diff, ofs;
    hsv_t h;
    r = int'(p.red);
    g = int'(p.green);
    b = int'(p.blue);
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    h = '0;
    h.brightness_value = 8'(mx);
    if (mx != 0) begin
      chroma = mx - mn;
      h.saturation = 8'((255 * chroma) / mx);
      if (h.saturation != 8'd0) begin
        if (mx == r) begin
          diff = g - b;
          ofs  = int'(HUE_OFS_RED);
        end else if (mx == g) begin
          diff = b - r;
          ofs  = int'(HUE_OFS_GREEN);
        end else begin
          diff = r - g;
          ofs  = int'(HUE_OFS_BLUE);
        end
        h.hue = 8'(ofs + (int'(HUE_SPAN) * diff) / chroma);
      end
    end
    return h;
  endfunction

  // random pixel, weighted toward ties, greys and extreme channels
  function automatic rgb_t random_pixel();
    rgb_t p;
    logic [7:0] hi, lo;
    p = rgb_t'($urandom);
    case ($urandom_range(0, 9))
      5: begin
        p.green = p.red;
        p.blue  = p.red;
      end
      6: begin
        hi = 8'($urandom_range(1, 255));
        lo = 8'($urandom_range(0, int'(hi) - 1));
        case ($urandom_range(0, 2))
          0: p = {hi, hi, lo};
          1: p = {lo, hi, hi};
          default: p = {hi, lo, hi};
        endcase
      end
      7: begin
        p.red   = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'($urandom_range(0, 1));
        p.green = ($urandom_range(0, 1) != 0) ? 8'd254 : 8'($urandom_range(0, 1));
        p.blue  = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'($urandom_range(0, 1));
      end
      8: p = {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
      9: begin
        hi = 8'($urandom_range(4, 255));
        p = {hi - 8'($urandom_range(0, 3)), hi - 8'($urandom_range(0, 3)),
             hi - 8'($urandom_range(0, 3))};
      end
      default: ;
    endcase
    return p;
  endfunction

  // holds the pixel until transfer, then records what it should convert to
  task automatic send_pixel(input rgb_t p, input hsv_t want);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hsv_expected.push_back(want);
  endtask

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // result side: random stall between transfers unless no_gaps is set, then checks against the oldest expectation
  initial begin
    int   stall;
    hsv_t want;
    wait (rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (hsv_expected.size() == 0) begin
        $error("result with nothing expected: hue %0d saturation %0d value %0d",
               out_data.hue, out_data.saturation, out_data.brightness_value);
        mismatches++;
      end else begin
        want = hsv_expected.pop_front();
        compare_field("hue", want.hue, out_data.hue);
        compare_field("saturation", want.saturation, out_data.saturation);
        compare_field("brightness_value", want.brightness_value, out_data.brightness_value);
      end
    end
  end

  initial begin
    rgb_t p;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < TABLE_ROWS; i++) begin
      p = PIXEL_TABLE[i].pix;
      send_pixel(p, PIXEL_TABLE[i].known ? PIXEL_TABLE[i].want : hsv_of(p));
    end

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      // every fourth block of 50 runs back to back on both sides
      no_gaps = ((n / 50) % 4) == 1;
      if (n == RANDOM_PIXELS / 2) begin
        // let the pipeline drain completely before carrying on
        in_valid <= 1'b0;
        do @(posedge clk); while (hsv_expected.size() != 0);
      end
      p = random_pixel();
      send_pixel(p, hsv_of(p));
    end
    in_valid <= 1'b0;
    no_gaps = 1'b0;

    while (hsv_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

/* sim.f */
hdl/rgbhsv_pkg.sv
hdl/rgb_to_hsv_convert.sv
test/testbench.sv
